### rtl/scb_pkg.sv
package scb_pkg;

  // configuration port
  localparam int unsigned CfgDataBits  = 12;
  localparam int unsigned CfgIndexBits = 2;

  typedef logic [CfgIndexBits-1:0] cfg_index_t;

  localparam cfg_index_t CfgFrameWidth  = 2'd0;
  localparam cfg_index_t CfgFrameHeight = 2'd1;
  localparam cfg_index_t CfgPixelFormat = 2'd2;

  // pixel formats
  localparam logic FmtRgb24 = 1'b0;
  localparam logic FmtYuyv  = 1'b1;

  // geometry
  localparam int unsigned DimBits   = 12;  // effective width / height, up to 2048
  localparam int unsigned CountBits = 11;  // column, row and scroll counters
  localparam int unsigned BarCount  = 8;
  localparam int unsigned BarBits   = 4;   // bar index over a strip two widths long

  typedef logic [DimBits-1:0]   dim_t;
  typedef logic [CountBits-1:0] count_t;

  localparam dim_t MinLineWidth = 12'd8;
  localparam dim_t MaxLineWidth = 12'd2048;
  localparam dim_t MinHeight    = 12'd1;
  localparam dim_t MaxHeight    = 12'd2048;

  localparam dim_t FrameWidthReset  = 12'd640;
  localparam dim_t FrameHeightReset = 12'd480;

  typedef logic [7:0] byte_t;

  typedef struct packed {
    byte_t b0;
    byte_t b1;
    byte_t b2;
  } pixel_t;

  // r, g, b of each bar
  function automatic pixel_t rgb_color(input logic [2:0] color);
    pixel_t px;
    unique case (color)
      3'd0:    px = '{8'd255, 8'd255, 8'd255};
      3'd1:    px = '{8'd255, 8'd255, 8'd0};
      3'd2:    px = '{8'd0,   8'd255, 8'd255};
      3'd3:    px = '{8'd0,   8'd255, 8'd0};
      3'd4:    px = '{8'd255, 8'd0,   8'd255};
      3'd5:    px = '{8'd255, 8'd0,   8'd0};
      3'd6:    px = '{8'd0,   8'd0,   8'd255};
      default: px = '{8'd0,   8'd0,   8'd0};
    endcase
    return px;
  endfunction

  // bt.601 y, u, v of each bar
  function automatic pixel_t yuv_color(input logic [2:0] color);
    pixel_t px;
    unique case (color)
      3'd0:    px = '{8'd235, 8'd128, 8'd128};
      3'd1:    px = '{8'd210, 8'd16,  8'd146};
      3'd2:    px = '{8'd170, 8'd166, 8'd16};
      3'd3:    px = '{8'd145, 8'd54,  8'd34};
      3'd4:    px = '{8'd106, 8'd202, 8'd222};
      3'd5:    px = '{8'd81,  8'd90,  8'd240};
      3'd6:    px = '{8'd41,  8'd240, 8'd110};
      default: px = '{8'd16,  8'd128, 8'd128};
    endcase
    return px;
  endfunction

endpackage

### rtl/scb_bar_lookup.sv
module scb_bar_lookup (
  input  scb_pkg::dim_t   width,
  input  scb_pkg::dim_t   pos,
  input  logic            pixel_format,
  output scb_pkg::pixel_t pixel
);

  localparam int unsigned Bars      = 2 * scb_pkg::BarCount;
  localparam int unsigned ProdBits  = scb_pkg::DimBits + 5;
  localparam int unsigned StartBits = ProdBits - 3;

  logic [StartBits-1:0]       bar_start [Bars];
  logic [ProdBits-1:0]        prod      [Bars];
  logic [scb_pkg::BarBits-1:0] bar;
  logic                       chroma_v;
  scb_pkg::pixel_t            rgb_px;
  scb_pkg::pixel_t            yuv_px;

  // bar starts: floor(i * width / 8), constant multiples of the width
  always_comb begin
    for (int i = 0; i < Bars; i++) begin
      prod[i]      = ProdBits'(i) * ProdBits'(width);
      bar_start[i] = prod[i][ProdBits-1:3];
    end
  end

  // starts rise strictly, so the last start at or below pos wins
  always_comb begin
    bar = '0;
    for (int i = 1; i < Bars; i++) begin
      if (bar_start[i] <= StartBits'(pos)) begin
        bar = scb_pkg::BarBits'(i);
      end
    end
  end

  // u at the first position of a bar, then alternating
  assign chroma_v = pos[0] ^ bar_start[bar][0];

  assign rgb_px = scb_pkg::rgb_color(bar[2:0]);
  assign yuv_px = scb_pkg::yuv_color(bar[2:0]);

  always_comb begin
    if (pixel_format == scb_pkg::FmtYuyv) begin
      pixel.b0 = yuv_px.b0;
      pixel.b1 = chroma_v ? yuv_px.b2 : yuv_px.b1;
      pixel.b2 = '0;
    end else begin
      pixel = rgb_px;
    end
  end

endmodule

### rtl/scrolling_color_bar_generator.sv
// scrolling color bar pattern source, one pixel per transfer
// latency: a result is valid in the cycle after its tick transfer
// throughput: one tick per cycle while out_ready stays high; a pixel tick meeting a scroll
//   offset at or past a shrunk width waits out the wrap sequencer's start and its 8 steps
// reset (rst, synchronous): registers back to 640 x 480 rgb24, counters and scroll to zero,
//   output register empty
module scrolling_color_bar_generator (
  input  logic                               clk,
  input  logic                               rst,
  // configuration writes
  input  logic                               cfg_write,
  input  logic [scb_pkg::CfgIndexBits-1:0]   cfg_index,
  input  logic [scb_pkg::CfgDataBits-1:0]    cfg_data,
  // tick channel
  input  logic                               in_valid,
  output logic                               in_ready,
  input  logic                               pixel_tick,
  // pixel channel
  output logic                               out_valid,
  input  logic                               out_ready,
  output logic [7:0]                         byte0,
  output logic [7:0]                         byte1,
  output logic [7:0]                         byte2,
  output logic                               line_end,
  output logic                               frame_end
);

  localparam int unsigned WrapBits = scb_pkg::DimBits + 7;  // width shifted by up to 7

  // configuration registers
  scb_pkg::dim_t   frame_width;
  scb_pkg::dim_t   frame_height;
  logic            pixel_format;

  // scan state
  scb_pkg::count_t scroll_offset;
  scb_pkg::count_t column_count;
  scb_pkg::count_t row_count;

  // offset wrap sequencer (restoring remainder, one quotient bit a cycle)
  logic            wrap_busy;
  logic [2:0]      wrap_step;
  logic [WrapBits-1:0] wrap_rem;
  logic [WrapBits-1:0] wrap_div;

  // output register
  scb_pkg::pixel_t pixel;
  logic            pixel_line_end;
  logic            pixel_frame_end;

  // datapath
  scb_pkg::dim_t   eff_width;
  scb_pkg::dim_t   eff_height;
  scb_pkg::count_t col_eff;
  scb_pkg::count_t row_eff;
  scb_pkg::dim_t   pos;
  scb_pkg::dim_t   offset_step;
  scb_pkg::dim_t   offset_wrapped;
  scb_pkg::pixel_t pixel_next;
  logic            offset_ok;
  logic            last_col;
  logic            last_row;
  logic            take;

  // clamp geometry to the supported range
  always_comb begin
    priority if (frame_width < scb_pkg::MinLineWidth) begin
      eff_width = scb_pkg::MinLineWidth;
    end else if (frame_width > scb_pkg::MaxLineWidth) begin
      eff_width = scb_pkg::MaxLineWidth;
    end else begin
      eff_width = frame_width;
    end
    priority if (frame_height < scb_pkg::MinHeight) begin
      eff_height = scb_pkg::MinHeight;
    end else if (frame_height > scb_pkg::MaxHeight) begin
      eff_height = scb_pkg::MaxHeight;
    end else begin
      eff_height = frame_height;
    end
  end

  // offset must sit below the width before a pixel is made
  assign offset_ok = {1'b0, scroll_offset} < eff_width;

  // counters left past a shrunk geometry restart at zero
  assign col_eff = ({1'b0, column_count} >= eff_width)  ? '0 : column_count;
  assign row_eff = ({1'b0, row_count}    >= eff_height) ? '0 : row_count;

  // position on the strip, 0 .. 2W-2
  assign pos = {1'b0, scroll_offset} + {1'b0, col_eff};

  assign last_col = ({1'b0, col_eff} == eff_width - 12'd1);
  assign last_row = ({1'b0, row_eff} == eff_height - 12'd1);

  // scroll advance by two, offset is already below the width
  assign offset_step    = {1'b0, scroll_offset} + 12'd2;
  assign offset_wrapped = (offset_step >= eff_width) ? offset_step - eff_width : offset_step;

  assign wrap_rem = {{(WrapBits - scb_pkg::CountBits){1'b0}}, scroll_offset};
  assign wrap_div = {7'd0, eff_width} << wrap_step;

  // output register frees up when its pixel is taken in the same cycle;
  // a pixel tick also waits for the offset to be back below the width
  assign in_ready = !wrap_busy && (offset_ok || !pixel_tick) && (!out_valid || out_ready);
  // a zero tick is consumed without a pixel
  assign take     = in_valid && in_ready && pixel_tick;

  scb_bar_lookup u_bar_lookup (
    .width        (eff_width),
    .pos          (pos),
    .pixel_format (pixel_format),
    .pixel        (pixel_next)
  );

  // control state
  always_ff @(posedge clk) begin
    if (rst) begin
      frame_width   <= scb_pkg::FrameWidthReset;
      frame_height  <= scb_pkg::FrameHeightReset;
      pixel_format  <= scb_pkg::FmtRgb24;
      scroll_offset <= '0;
      column_count  <= '0;
      row_count     <= '0;
      wrap_busy     <= 1'b0;
      wrap_step     <= '0;
      out_valid     <= 1'b0;
    end else begin
      // register writes; unknown indexes are dropped
      if (cfg_write) begin
        unique case (cfg_index)
          scb_pkg::CfgFrameWidth:  frame_width  <= cfg_data;
          scb_pkg::CfgFrameHeight: frame_height <= cfg_data;
          scb_pkg::CfgPixelFormat: pixel_format <= cfg_data[0];
          default: ;
        endcase
      end

      if (wrap_busy) begin
        // subtract width << step where it fits, steps 7 down to 0
        if (wrap_rem >= wrap_div) begin
          scroll_offset <= scb_pkg::CountBits'(wrap_rem - wrap_div);
        end
        if (wrap_step == 3'd0) begin
          wrap_busy <= 1'b0;
        end else begin
          wrap_step <= wrap_step - 3'd1;
        end
      end else if (!offset_ok && in_valid && pixel_tick) begin
        // a pixel waits on an offset past a shrunk width: reduce it modulo the width
        wrap_busy <= 1'b1;
        wrap_step <= 3'd7;
      end else if (take) begin
        if (last_col) begin
          column_count <= '0;
          if (last_row) begin
            row_count     <= '0;
            scroll_offset <= offset_wrapped[scb_pkg::CountBits-1:0];
          end else begin
            row_count <= row_eff + 11'd1;
          end
        end else begin
          column_count <= col_eff + 11'd1;
          row_count    <= row_eff;
        end
      end

      if (take) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // payload of the output register
  always_ff @(posedge clk) begin
    if (take) begin
      pixel           <= pixel_next;
      pixel_line_end  <= last_col;
      pixel_frame_end <= last_col && last_row;
    end
  end

  assign byte0     = pixel.b0;
  assign byte1     = pixel.b1;
  assign byte2     = pixel.b2;
  assign line_end  = pixel_line_end;
  assign frame_end = pixel_frame_end;

endmodule

### tb/sv/scrolling_color_bar_generator_tb.sv
module scrolling_color_bar_generator_tb;
  timeunit 1ns;
  timeprecision 1ps;

  // register index with no register behind it, writes to it are dropped
  localparam scb_pkg::cfg_index_t CfgNoReg = 2'd3;

  localparam int unsigned SettleCycles = 16;      // quiet time before a register write
  localparam int unsigned TailCycles   = 16;      // drain time after the last result
  localparam int unsigned ItemTarget   = 1350;    // stop issuing random phases here
  localparam int unsigned CalmAfter    = 1150;    // no idling on either side past this
  localparam int unsigned CycleLimit   = 800_000;

  // one pixel as it leaves the block
  typedef struct packed {
    scb_pkg::byte_t luma_red;
    scb_pkg::byte_t chroma_green;
    scb_pkg::byte_t blue;
    logic           line_last;
    logic           frame_last;
  } bar_pixel_t;

  // tracks geometry, scroll and position, and holds the pixels still owed
  class color_bar_tracker;
    scb_pkg::dim_t width_reg;
    scb_pkg::dim_t height_reg;
    logic          yuyv_reg;
    int unsigned   scroll;
    int unsigned   column;
    int unsigned   row;
    bar_pixel_t    owed[$];
    int unsigned   errors;

    function new();
      width_reg  = scb_pkg::FrameWidthReset;
      height_reg = scb_pkg::FrameHeightReset;
      yuyv_reg   = scb_pkg::FmtRgb24;
      scroll     = 0;
      column     = 0;
      row        = 0;
      errors     = 0;
    endfunction

    function void write_reg(scb_pkg::cfg_index_t idx, scb_pkg::dim_t data);
      case (idx)
        scb_pkg::CfgFrameWidth:  width_reg = data;
        scb_pkg::CfgFrameHeight: height_reg = data;
        scb_pkg::CfgPixelFormat: yuyv_reg = data[0];
        default: ;
      endcase
    endfunction

    // work out the pixel that one accepted tick produces
    function void note_tick(logic tick);
      int unsigned w, h, p, bar, start, color;
      int          r, g, b, y, u, v;
      bar_pixel_t  px;
      if (!tick) return;
      w = width_reg;
      if (w < scb_pkg::MinLineWidth) w = scb_pkg::MinLineWidth;
      if (w > scb_pkg::MaxLineWidth) w = scb_pkg::MaxLineWidth;
      h = height_reg;
      if (h < scb_pkg::MinHeight) h = scb_pkg::MinHeight;
      if (h > scb_pkg::MaxHeight) h = scb_pkg::MaxHeight;
      // geometry may have shrunk under the counters
      if (scroll >= w) scroll = scroll % w;
      if (column >= w) column = 0;
      if (row >= h) row = 0;

      // position on the strip two widths long, bar is the last start not past it
      p = scroll + column;
      bar = 0;
      for (int i = 1; i < 2 * scb_pkg::BarCount; i++)
        if ((i * w) / scb_pkg::BarCount <= p) bar = i;
      start = (bar * w) / scb_pkg::BarCount;
      color = bar % scb_pkg::BarCount;

      // bar order white yellow cyan green magenta red blue black
      r = color[1] ? 0 : 255;
      g = color[2] ? 0 : 255;
      b = color[0] ? 0 : 255;
      if (yuyv_reg == scb_pkg::FmtYuyv) begin
        // bt.601 in 16-bit fixed point, shift rounded to nearest
        y = ((16829 * r + 33039 * g + 6416 * b + 32768) >>> 16) + 16;
        u = ((-9714 * r - 19070 * g + 28784 * b + 32768) >>> 16) + 128;
        v = ((28784 * r - 24103 * g - 4681 * b + 32768) >>> 16) + 128;
        px.luma_red     = y[7:0];
        px.chroma_green = ((p - start) % 2 == 1) ? v[7:0] : u[7:0];
        px.blue         = '0;
      end else begin
        px.luma_red     = r[7:0];
        px.chroma_green = g[7:0];
        px.blue         = b[7:0];
      end
      px.line_last  = (column == w - 1);
      px.frame_last = px.line_last && (row == h - 1);

      if (px.line_last) begin
        column = 0;
        if (px.frame_last) begin
          row = 0;
          scroll = (scroll + 2) % w;
        end else begin
          row = row + 1;
        end
      end else begin
        column = column + 1;
      end
      owed.push_back(px);
    endfunction

    task report(string msg);
      $display("mismatch: %s", msg);
      errors++;
    endtask

    task compare_field(string name, logic [7:0] got, logic [7:0] want);
      if (got !== want)
        report($sformatf("%s got %0d want %0d (%0d pixels still owed)",
                         name, got, want, owed.size()));
    endtask

    task check_pixel(bar_pixel_t got);
      bar_pixel_t want;
      if (owed.size() == 0) begin
        report("pixel transfer with no tick behind it");
        return;
      end
      want = owed.pop_front();
      compare_field("byte0", got.luma_red, want.luma_red);
      compare_field("byte1", got.chroma_green, want.chroma_green);
      compare_field("byte2", got.blue, want.blue);
      compare_field("line_end", 8'(got.line_last), 8'(want.line_last));
      compare_field("frame_end", 8'(got.frame_last), 8'(want.frame_last));
    endtask
  endclass

  logic                clk = 1'b0;
  logic                rst;
  logic                cfg_write;
  scb_pkg::cfg_index_t cfg_index;
  scb_pkg::dim_t       cfg_data;
  logic                in_valid;
  logic                in_ready;
  logic                pixel_tick;
  logic                out_valid;
  logic                out_ready;
  logic [7:0]          byte0;
  logic [7:0]          byte1;
  logic [7:0]          byte2;
  logic                line_end;
  logic                frame_end;

  color_bar_tracker tracker = new();
  int unsigned      items_sent = 0;    // accepted ticks, zero ticks included
  int unsigned      cycles = 0;
  bit               idle_off = 1'b0;   // when set, neither side idles

  scrolling_color_bar_generator DUT (
    .clk        (clk),
    .rst        (rst),
    .cfg_write  (cfg_write),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .pixel_tick (pixel_tick),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .byte0      (byte0),
    .byte1      (byte1),
    .byte2      (byte2),
    .line_end   (line_end),
    .frame_end  (frame_end)
  );

  // 2 ns clock
  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // hard stop in case a handshake never completes
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CycleLimit) begin
      $display("scrolling_color_bar_generator_tb: done, errors");
      $finish;
    end
  end

  // pixel side: every transfer is checked against the oldest owed pixel
  always @(posedge clk) begin
    if (!rst && out_valid && out_ready)
      tracker.check_pixel('{byte0, byte1, byte2, line_end, frame_end});
  end

  // pixel side back-pressure, random stall bursts
  initial begin
    forever begin
      if (!idle_off && $urandom_range(0, 4) == 0) begin
        out_ready <= 1'b0;
        repeat ($urandom_range(1, 16)) @(posedge clk);
      end
      out_ready <= 1'b1;
      @(posedge clk);
    end
  end

  // one tick transfer; valid stays up afterwards unless a gap follows
  task automatic send_tick(logic tick);
    in_valid   <= 1'b1;
    pixel_tick <= tick;
    do @(posedge clk); while (!in_ready);
    tracker.note_tick(tick);
    items_sent++;
    if (!idle_off && $urandom_range(0, 3) == 0) begin
      in_valid   <= 1'b0;
      pixel_tick <= 1'($urandom_range(0, 1));
      repeat ($urandom_range(1, 16)) @(posedge clk);
    end
  endtask

  task automatic send_pixels(int unsigned n);
    repeat (n) send_tick(1'b1);
  endtask

  // drop valid at the end of a burst of ticks
  task automatic close_burst();
    in_valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic wait_drained();
    while (tracker.owed.size() != 0) @(posedge clk);
  endtask

  // register write, after the block has settled
  task automatic write_reg(scb_pkg::cfg_index_t idx, scb_pkg::dim_t data);
    repeat (SettleCycles) @(posedge clk);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    tracker.write_reg(idx, data);
    cfg_write <= 1'b0;
  endtask

  // random geometry and format, then a run of mostly real ticks
  task automatic random_phase();
    scb_pkg::dim_t w_data;
    scb_pkg::dim_t h_data;
    int unsigned   pick;
    pick = $urandom_range(0, 15);
    if (pick == 0)      w_data = scb_pkg::dim_t'($urandom_range(0, 7));       // clamps up to 8
    else if (pick == 1) w_data = scb_pkg::dim_t'($urandom_range(2049, 4095)); // clamps to 2048
    else if (pick == 2) w_data = scb_pkg::MaxLineWidth;
    else                w_data = scb_pkg::dim_t'($urandom_range(8, 40));
    pick = $urandom_range(0, 15);
    if (pick == 0)      h_data = '0;                                           // clamps up to 1
    else if (pick == 1) h_data = scb_pkg::dim_t'($urandom_range(2048, 4095));
    else                h_data = scb_pkg::dim_t'($urandom_range(1, 6));

    idle_off = (items_sent >= CalmAfter) || ($urandom_range(0, 4) == 0);
    wait_drained();
    write_reg(scb_pkg::CfgFrameWidth, w_data);
    write_reg(scb_pkg::CfgFrameHeight, h_data);
    if ($urandom_range(0, 3) != 0)
      write_reg(scb_pkg::CfgPixelFormat, scb_pkg::dim_t'($urandom_range(0, 4095)));
    repeat ($urandom_range(20, 120)) send_tick($urandom_range(0, 7) != 0);
    close_burst();
  endtask

  initial begin
    rst        <= 1'b1;
    cfg_write  <= 1'b0;
    cfg_index  <= scb_pkg::CfgFrameWidth;
    cfg_data   <= '0;
    in_valid   <= 1'b0;
    pixel_tick <= 1'b0;
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    // reset geometry, with a zero tick in between
    send_tick(1'b1);
    send_tick(1'b0);
    send_tick(1'b1);
    close_burst();

    // smallest frame from clamped zeros, yuyv with spare data bits set,
    // one pixel per bar, from the column left by the ticks before; the unused index must change nothing
    wait_drained();
    write_reg(scb_pkg::CfgFrameWidth, '0);
    write_reg(scb_pkg::CfgFrameHeight, '0);
    write_reg(scb_pkg::CfgPixelFormat, 12'hFFF);
    write_reg(CfgNoReg, 12'hFFF);
    send_pixels(8);
    send_tick(1'b0);
    close_burst();

    // all-ones geometry clamps to the largest frame, format bit cleared under set bits
    wait_drained();
    write_reg(scb_pkg::CfgFrameWidth, 12'hFFF);
    write_reg(scb_pkg::CfgFrameHeight, 12'hFFF);
    write_reg(scb_pkg::CfgPixelFormat, 12'hFFE);
    send_pixels(4);
    close_burst();

    // two-pixel bars in yuyv so chroma goes u then v within a bar
    wait_drained();
    write_reg(scb_pkg::CfgFrameWidth, 12'd16);
    write_reg(scb_pkg::CfgFrameHeight, 12'd1);
    write_reg(scb_pkg::CfgPixelFormat, 12'(scb_pkg::FmtYuyv));
    send_pixels(16);
    close_burst();

    // scroll offset runs up past 14 and round to 2, then width shrinks at the start of a line
    send_pixels(6 * 16 + 10);
    close_burst();
    wait_drained();
    write_reg(scb_pkg::CfgFrameWidth, 12'd8);
    write_reg(scb_pkg::CfgFrameHeight, 12'd4);
    // into the last row, then shrink height under the row counter
    send_pixels(3 * 8 + 2);
    close_burst();
    wait_drained();
    write_reg(scb_pkg::CfgFrameHeight, 12'd2);
    send_pixels(20);
    close_burst();

    while (items_sent < ItemTarget) random_phase();

    wait_drained();
    repeat (TailCycles) @(posedge clk);
    if (tracker.errors == 0)
      $display("scrolling_color_bar_generator_tb: done, clean");
    else
      $display("scrolling_color_bar_generator_tb: done, errors");
    $finish;
  end

endmodule

### sim.f
rtl/scb_pkg.sv
rtl/scb_bar_lookup.sv
rtl/scrolling_color_bar_generator.sv
tb/sv/scrolling_color_bar_generator_tb.sv
